// ===== rtl/rtpl24_pkg.sv =====
// Shared types and constants for the RTP L24 stereo packetizer.
// No dependencies.
package rtpl24_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int L24_W        = 24;
	localparam int BYTE_W       = 8;
	localparam int HDR_BYTES    = 12;
	localparam int FRAME_BYTES  = 6;
	localparam int MAX_BYTES    = HDR_BYTES + FRAME_BYTES;
	localparam int BUF_W        = MAX_BYTES * BYTE_W;
	localparam int CNT_W        = 5;
	localparam int POS_W        = 6;
	localparam int SEQ_W        = 16;
	localparam int TS_W         = 32;
	localparam int SSRC_W       = 32;
	localparam int PT_W         = 7;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [BYTE_W-1:0] RTP_V2_BYTE = 8'h80;
	localparam logic [PT_W-1:0]   PT_RESET    = 7'd97;
	localparam logic [L24_W-1:0]  L24_POS_MAX = 24'h7F_FFFF;
	localparam logic [L24_W-1:0]  L24_NEG_MIN = 24'h80_0000;

	localparam logic [CNT_W-1:0]  CNT_HDR   = CNT_W'(MAX_BYTES);
	localparam logic [CNT_W-1:0]  CNT_FRAME = CNT_W'(FRAME_BYTES);

	typedef enum logic [1:0] {
		REG_SSRC      = 2'd0,
		REG_START_SEQ = 2'd1,
		REG_START_TS  = 2'd2,
		REG_PT        = 2'd3
	} reg_idx_t;

	// Saturate a 32-bit two's complement sample to its 24-bit pattern.
	function automatic logic [L24_W-1:0] sat_l24(input logic [SAMPLE_W-1:0] s);
		logic in_range;
		in_range = (s[SAMPLE_W-1:L24_W-1] == '0) || (s[SAMPLE_W-1:L24_W-1] == '1);
		if (in_range)
			return s[L24_W-1:0];
		else if (s[SAMPLE_W-1])
			return L24_NEG_MIN;
		else
			return L24_POS_MAX;
	endfunction

endpackage

// ===== rtl/rtp_l24_audio_packetizer.sv =====
// RTP L24 stereo packetizer, top level: config registers, header build, byte serializer.
// Depends on rtpl24_pkg.
//
// One input item is a stereo frame (two signed 32-bit samples). Each sample is
// saturated to 24 bits and sent big-endian, left then right, as six payload
// bytes. The first frame of each packet is preceded by the 12-byte RTP header
// (0x80, payload type with marker 0, sequence, timestamp, SSRC, all big-endian).
// After FRAMES_PER_PACKET frames the sequence number steps by one and the
// timestamp by FRAMES_PER_PACKET. Bytes leave one per cycle on a byte-wide
// output while out_ready is high; a frame is 6 bytes, or 18 when it opens a
// packet, and that byte port sets the sustained rate. Input side: frames are
// registered fully formatted in one stage, so one frame can wait while the
// previous one is being shifted out, and a new frame is taken in the cycle the
// shifter loads. end_of_item marks the last byte of each frame, end_of_packet
// the last byte of a packet. Config registers (APB, byte address 4*index):
// 0 SSRC, 1 start sequence (write reloads the sequence counter), 2 start
// timestamp (write reloads the timestamp counter), 3 payload type (reset 97).
// Writes are meant for when no frame is in flight.
module rtp_l24_audio_packetizer #(
	parameter int FRAMES_PER_PACKET = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rtpl24_pkg::ADDR_W-1:0]       paddr,
	input  logic [rtpl24_pkg::DATA_W-1:0]       pwdata,
	output logic [rtpl24_pkg::DATA_W-1:0]       prdata,
	output logic                                pready,
	// frame input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [rtpl24_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [rtpl24_pkg::SAMPLE_W-1:0] right_sample,
	// byte output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rtpl24_pkg::BYTE_W-1:0]       packet_byte,
	output logic                                end_of_item,
	output logic                                end_of_packet
);

	localparam logic [rtpl24_pkg::POS_W-1:0] LAST_POS =
		rtpl24_pkg::POS_W'(FRAMES_PER_PACKET - 1);
	localparam logic [rtpl24_pkg::TS_W-1:0]  TS_STEP  =
		rtpl24_pkg::TS_W'(FRAMES_PER_PACKET);

	// config registers
	logic [rtpl24_pkg::SSRC_W-1:0] ssrc_q;
	logic [rtpl24_pkg::SEQ_W-1:0]  start_seq_q;
	logic [rtpl24_pkg::TS_W-1:0]   start_ts_q;
	logic [rtpl24_pkg::PT_W-1:0]   pt_q;

	// packet state
	logic [rtpl24_pkg::POS_W-1:0]  pos_q;
	logic [rtpl24_pkg::SEQ_W-1:0]  seq_q;
	logic [rtpl24_pkg::TS_W-1:0]   ts_q;

	// formatted frame waiting for the serializer
	logic                          valid_s1;
	logic [rtpl24_pkg::BUF_W-1:0]  buf_s1;
	logic [rtpl24_pkg::CNT_W-1:0]  cnt_s1;
	logic                          eop_s1;

	// serializer
	logic [rtpl24_pkg::BUF_W-1:0]  obuf_q;
	logic [rtpl24_pkg::CNT_W-1:0]  ocnt_q;
	logic                          oeop_q;

	logic                          cfg_wr;
	rtpl24_pkg::reg_idx_t          cfg_idx;
	logic                          in_acc;
	logic                          out_acc;
	logic                          load_out;
	logic                          last_frame;
	logic [rtpl24_pkg::L24_W-1:0]  left_l24;
	logic [rtpl24_pkg::L24_W-1:0]  right_l24;
	logic [rtpl24_pkg::BUF_W-1:0]  buf_d;
	logic [rtpl24_pkg::CNT_W-1:0]  cnt_d;

	assign pready  = 1'b1;
	assign cfg_idx = rtpl24_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		unique case (cfg_idx)
			rtpl24_pkg::REG_SSRC:      prdata = ssrc_q;
			rtpl24_pkg::REG_START_SEQ: prdata = rtpl24_pkg::DATA_W'(start_seq_q);
			rtpl24_pkg::REG_START_TS:  prdata = start_ts_q;
			rtpl24_pkg::REG_PT:        prdata = rtpl24_pkg::DATA_W'(pt_q);
			default:                   prdata = '0;
		endcase
	end

	// handshakes
	assign out_valid = (ocnt_q != '0);
	assign out_acc   = out_valid & out_ready;
	assign load_out  = valid_s1 & ((ocnt_q == '0) | ((ocnt_q == 5'd1) & out_ready));
	assign in_ready  = ~valid_s1 | load_out;
	assign in_acc    = in_valid & in_ready;

	// frame formatting
	assign left_l24   = rtpl24_pkg::sat_l24(left_sample);
	assign right_l24  = rtpl24_pkg::sat_l24(right_sample);
	assign last_frame = (pos_q == LAST_POS);

	always_comb begin
		if (pos_q == '0) begin
			buf_d = {rtpl24_pkg::RTP_V2_BYTE, 1'b0, pt_q, seq_q, ts_q, ssrc_q,
				left_l24, right_l24};
			cnt_d = rtpl24_pkg::CNT_HDR;
		end else begin
			// payload goes to the top so it leaves first
			buf_d = {left_l24, right_l24,
				(rtpl24_pkg::BUF_W - 2*rtpl24_pkg::L24_W)'(0)};
			cnt_d = rtpl24_pkg::CNT_FRAME;
		end
	end

	// config registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q      <= '0;
			start_seq_q <= '0;
			start_ts_q  <= '0;
			pt_q        <= rtpl24_pkg::PT_RESET;
			pos_q       <= '0;
			seq_q       <= '0;
			ts_q        <= '0;
		end else begin
			if (in_acc) begin
				if (last_frame) begin
					pos_q <= '0;
					seq_q <= seq_q + 1'b1;
					ts_q  <= ts_q + TS_STEP;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cfg_wr) begin
				unique case (cfg_idx)
					rtpl24_pkg::REG_SSRC: ssrc_q <= pwdata;
					rtpl24_pkg::REG_START_SEQ: begin
						start_seq_q <= pwdata[rtpl24_pkg::SEQ_W-1:0];
						seq_q       <= pwdata[rtpl24_pkg::SEQ_W-1:0];
					end
					rtpl24_pkg::REG_START_TS: begin
						start_ts_q <= pwdata;
						ts_q       <= pwdata;
					end
					rtpl24_pkg::REG_PT: pt_q <= pwdata[rtpl24_pkg::PT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_s1 <= buf_d;
			cnt_s1 <= cnt_d;
			eop_s1 <= last_frame;
		end
	end

	// serializer control: remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
		end else if (load_out) begin
			ocnt_q <= cnt_s1;
		end else if (out_acc) begin
			ocnt_q <= ocnt_q - 1'b1;
		end
	end

	// serializer payload: shift out MSB byte first
	always_ff @(posedge clk) begin
		if (load_out) begin
			obuf_q <= buf_s1;
			oeop_q <= eop_s1;
		end else if (out_acc) begin
			obuf_q <= {obuf_q[rtpl24_pkg::BUF_W-rtpl24_pkg::BYTE_W-1:0],
				rtpl24_pkg::BYTE_W'(0)};
		end
	end

	assign packet_byte   = obuf_q[rtpl24_pkg::BUF_W-1 -: rtpl24_pkg::BYTE_W];
	assign end_of_item   = (ocnt_q == 5'd1);
	assign end_of_packet = end_of_item & oeop_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rtp_l24_audio_packetizer: frames in, RTP bytes out.
// Depends on rtpl24_pkg and the packetizer RTL; keeps its own packet predictor.
module testbench;
	import rtpl24_pkg::*;

	localparam int FRAMES_PER_PACKET = 48;
	// cycles to let pass once nothing is expected: one full frame plus margin
	localparam int SETTLE_CYCLES     = 2 * MAX_BYTES;
	localparam int RANDOM_PHASES     = 4;
	localparam int FRAMES_PER_PHASE  = 35;

	// one byte of the packet stream as the checker sees it
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eoi;
		logic              eop;
	} pkt_byte_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [ADDR_W-1:0]           paddr = '0;
	logic [DATA_W-1:0]           pwdata = '0;
	logic [DATA_W-1:0]           prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [SAMPLE_W-1:0]  left_sample = '0;
	logic signed [SAMPLE_W-1:0]  right_sample = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [BYTE_W-1:0]           packet_byte;
	logic                        end_of_item;
	logic                        end_of_packet;

	// Predictor state: register shadows (as read back) and the live counters.
	logic [DATA_W-1:0] reg_shadow [4] = '{32'd0, 32'd0, 32'd0, 32'(PT_RESET)};
	logic [SEQ_W-1:0]  seq_cnt = '0;
	logic [TS_W-1:0]   ts_cnt = '0;
	int unsigned       frames_in_pkt = 0;

	pkt_byte_t         expected_bytes [$];
	int unsigned       mismatches = 0;

	// Traffic shaping knobs, flipped by the tests.
	bit                tx_steady = 1'b0;   // sender offers items back to back
	bit                rx_steady = 1'b0;   // receiver never stalls
	int unsigned       rx_hold_req = 0;    // nonzero: receiver holds off for a stretch set by this value

	rtp_l24_audio_packetizer #(
		.FRAMES_PER_PACKET(FRAMES_PER_PACKET)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_byte  (packet_byte),
		.end_of_item  (end_of_item),
		.end_of_packet(end_of_packet)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop. Worst case is roughly 400 items x 18 bytes x a long stall
	// per byte, well under this.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Idle length: mostly none, some short, a few long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Samples: mostly legal 24-bit values, plus full-range noise, the values
	// right around the saturation limits and the 32-bit extremes.
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic [31:0] r;
		int          base;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return {{8{r[23]}}, r[23:0]};
			6, 7:             return r;
			8: begin
				base = $urandom_range(0, 1) ? 8388607 : -8388608;
				return base + int'($urandom_range(0, 2)) - 1;
			end
			default:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	// Register values lean on the extremes; upper bits beyond a register's
	// width are left set on purpose so masking gets exercised.
	function automatic logic [DATA_W-1:0] rand_reg_value();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [L24_W-1:0] to_l24(input logic signed [SAMPLE_W-1:0] s);
		if (s > 32'sd8388607)
			return L24_POS_MAX;
		if (s < -32'sd8388608)
			return L24_NEG_MIN;
		return s[L24_W-1:0];
	endfunction

	// Queue the bytes that one accepted frame must produce, then advance the
	// packet position and, on the last frame, the sequence and timestamp.
	function automatic void packetize_frame(input logic signed [SAMPLE_W-1:0] l,
	                                        input logic signed [SAMPLE_W-1:0] r);
		logic [BUF_W-1:0] bytes;
		int unsigned      n;
		pkt_byte_t        b;
		bit               closes_pkt;
		if (frames_in_pkt == 0) begin
			bytes = {RTP_V2_BYTE, 1'b0, reg_shadow[REG_PT][PT_W-1:0], seq_cnt, ts_cnt,
			         reg_shadow[REG_SSRC], to_l24(l), to_l24(r)};
			n = MAX_BYTES;
		end else begin
			bytes = {to_l24(l), to_l24(r), {(HDR_BYTES * BYTE_W){1'b0}}};
			n = FRAME_BYTES;
		end
		closes_pkt = (frames_in_pkt + 1 == FRAMES_PER_PACKET);
		for (int i = 0; i < n; i++) begin
			b.data = bytes[BUF_W - 1 - BYTE_W * i -: BYTE_W];
			b.eoi  = (i == n - 1);
			b.eop  = (i == n - 1) && closes_pkt;
			expected_bytes.push_back(b);
		end
		if (closes_pkt) begin
			frames_in_pkt = 0;
			seq_cnt       = seq_cnt + 1'b1;
			ts_cnt        = ts_cnt + TS_W'(FRAMES_PER_PACKET);
		end else begin
			frames_in_pkt++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Byte checker: every accepted byte against the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		pkt_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected byte %02h (eoi %b eop %b)", packet_byte, end_of_item,
				       end_of_packet);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				if (packet_byte !== want.data) begin
					$error("packet_byte: expected %02h, got %02h", want.data, packet_byte);
					mismatches++;
				end
				if (end_of_item !== want.eoi) begin
					$error("end_of_item: expected %b, got %b", want.eoi, end_of_item);
					mismatches++;
				end
				if (end_of_packet !== want.eop) begin
					$error("end_of_packet: expected %b, got %b", want.eop, end_of_packet);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, or a long hold-off counted here
	// ------------------------------------------------------------------

	initial begin : receiver
		int unsigned stall_left;
		int unsigned hold;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold        = rx_hold_req;
				rx_hold_req = 0;
				stall_left  = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = gap_len();
				out_ready <= (stall_left == 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared driver tasks (all start and end right after a rising edge)
	// ------------------------------------------------------------------

	// Offer one frame and wait for the handshake. Valid is only lowered when
	// a gap comes first, so back-to-back items keep it high.
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
	                          input logic signed [SAMPLE_W-1:0] r);
		int unsigned g;
		g = tx_steady ? 0 : gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		packetize_frame(l, r);
	endtask

	task automatic send_frames(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_frame(rand_sample(), rand_sample());
	endtask

	// Stop offering, wait for every expected byte, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB read, compared with the shadow copy.
	task automatic check_reg(input reg_idx_t idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== reg_shadow[idx]) begin
			$error("prdata[%s]: expected %08h, got %08h", idx.name(), reg_shadow[idx], prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB write followed by a read-back. Only called with nothing in flight.
	task automatic program_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		case (idx)
			REG_SSRC:      reg_shadow[idx] = value;
			REG_START_SEQ: begin
				reg_shadow[idx] = {{(DATA_W - SEQ_W){1'b0}}, value[SEQ_W-1:0]};
				seq_cnt         = value[SEQ_W-1:0];
			end
			REG_START_TS:  begin
				reg_shadow[idx] = value;
				ts_cnt          = value;
			end
			REG_PT:        reg_shadow[idx] = {{(DATA_W - PT_W){1'b0}}, value[PT_W-1:0]};
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_reg(idx);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values, and a few frames under them (payload type 97,
	// sequence and timestamp zero).
	task automatic test_reset_values();
		check_reg(REG_SSRC);
		check_reg(REG_START_SEQ);
		check_reg(REG_START_TS);
		check_reg(REG_PT);
		send_frame(32'sd0, -32'sd1);
		send_frame(32'sd1, 32'sd0);
		send_frame(-32'sd1, 32'sd1);
	endtask

	// Sample corners: at, just inside and just outside the 24-bit limits,
	// the 32-bit extremes and alternating bit patterns.
	task automatic test_saturation();
		logic [31:0] corner_vals [16] = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0080_0000,
			32'hFF80_0000, 32'hFF7F_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h00FF_FFFF, 32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h0055_5555, 32'hFFAA_AAAA, 32'h007F_FFFE, 32'hFF80_0001
		};
		for (int i = 0; i < 16; i++)
			send_frame(corner_vals[i], corner_vals[15 - i]);
	endtask

	// Counters reloaded while a packet is half sent: the current packet keeps
	// its header, the next one shows the reloaded values plus one packet step.
	task automatic test_reload_mid_packet();
		drain();
		program_reg(REG_START_SEQ, rand_reg_value());
		program_reg(REG_START_TS, rand_reg_value());
		program_reg(REG_SSRC, 32'hDEAD_BEEF);
		program_reg(REG_PT, 32'h0000_0000);
		send_frames(FRAMES_PER_PACKET - frames_in_pkt + 3);
	endtask

	// Both counters at the top of their range so they wrap across packets.
	// The first packet runs with no idling on either side.
	task automatic test_counter_wrap();
		if (frames_in_pkt != 0)
			send_frames(FRAMES_PER_PACKET - frames_in_pkt);
		drain();
		program_reg(REG_START_SEQ, 32'hABCD_FFFF);
		program_reg(REG_START_TS, 32'hFFFF_FFE8);
		program_reg(REG_SSRC, 32'hFFFF_FFFF);
		program_reg(REG_PT, 32'hFFFF_FFFF);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_frames(FRAMES_PER_PACKET);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		send_frames(FRAMES_PER_PACKET);
	endtask

	// Receiver holds off long while the sender keeps offering, so the block
	// fills and stalls its input; then the sender waits for the output to
	// empty before going on.
	task automatic test_backpressure();
		rx_hold_req = 400;
		tx_steady   = 1'b1;
		send_frames(30);
		tx_steady   = 1'b0;
		drain();
		send_frames(10);
	endtask

	// Random traffic over several register settings: first all minimums,
	// then all maximums, then random picks.
	task automatic test_random_phases();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			if (p == 0) begin
				program_reg(REG_SSRC, '0);
				program_reg(REG_START_SEQ, '0);
				program_reg(REG_START_TS, '0);
				program_reg(REG_PT, '0);
			end else if (p == 1) begin
				program_reg(REG_SSRC, '1);
				program_reg(REG_START_SEQ, '1);
				program_reg(REG_START_TS, '1);
				program_reg(REG_PT, '1);
			end else begin
				program_reg(REG_SSRC, rand_reg_value());
				program_reg(REG_START_SEQ, rand_reg_value());
				program_reg(REG_START_TS, rand_reg_value());
				program_reg(REG_PT, rand_reg_value());
			end
			send_frames(FRAMES_PER_PHASE);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_saturation();
		test_reload_mid_packet();
		test_counter_wrap();
		test_backpressure();
		test_random_phases();
		drain();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
